// ===== rtl/spectrum_bar_graph_renderer_defines.svh =====
// Assertion helpers for the spectrum bar graph renderer.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef SPECTRUM_BAR_GRAPH_RENDERER_DEFINES_SVH
`define SPECTRUM_BAR_GRAPH_RENDERER_DEFINES_SVH

// same-cycle implication
`define SBGR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sbgr: check failed");

// next-cycle implication
`define SBGR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sbgr: check failed");

`endif

// ===== rtl/sbgr_pkg.sv =====
package sbgr_pkg;

  localparam int MAX_BINS_DEF      = 1024;
  localparam int MAX_WIDTH_DEF     = 1024;
  localparam int CURVE_ENTRIES_DEF = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;

  // divider operand widths: level dividend is sum * 0.8 scale (45 bits)
  localparam int DIV_NUM_W = 45;
  localparam int DIV_DEN_W = 14;

  localparam logic [15:0] SCALE_080  = 16'd52429;
  localparam logic [15:0] FULL_SCALE = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_COUNT      = 3'd0,
    CFG_CHANNEL_COUNT  = 3'd1,
    CFG_DRAW_MODE      = 3'd2,
    CFG_AREA_WIDTH     = 3'd3,
    CFG_AREA_HEIGHT    = 3'd4,
    CFG_HORIZONTAL_LOG = 3'd5,
    CFG_VERTICAL_LOG   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/sbgr_div.sv =====
module sbgr_div import sbgr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIV_NUM_W-1:0] quot_q, quot_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W+1:0] diff;

  // restoring division, one quotient bit per cycle
  assign diff = {1'b0, rem_q, quot_q[DIV_NUM_W-1]} - {2'b00, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      cnt_d  = CNT_W'(DIV_NUM_W);
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!diff[DIV_DEN_W+1]) begin
        rem_d  = diff[DIV_DEN_W-1:0];
        quot_d = {quot_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[DIV_DEN_W-2:0], quot_q[DIV_NUM_W-1]};
        quot_d = {quot_q[DIV_NUM_W-2:0], 1'b0};
      end
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = (cnt_q != '0);
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/spectrum_bar_graph_renderer.sv =====
// Spectrum bar graph renderer.
// Input stream (s_axis): one request per cycle at most. tuser = opcode.
//   Write request (opcode 0) stores both channel magnitudes of one bin in
//   the bin memory and gives no result.
//   Draw request (opcode 1) turns column_index into one rectangle result.
// Output stream (m_axis): tdata = rect fields and level, tuser = fill.
// Configuration: cfg_we_i / cfg_idx_i / cfg_wdata_i, to be written only while
//   idle; the user must keep to this, as the block does not enforce it.
// A draw request maps its start and end bins (the last log column skips the
//   end divide), sums the bins of the range, divides for the level and maps
//   the height. A column outside the column count skips all of this and
//   gives an all-zero result.
// Throughput is one request at a time: the shared 45-step radix-2 divider
//   and the bin memory read port, walked one bin per cycle, set the figure.
// The result sits in an output register; when the receiver stalls the next
//   request is still taken and worked on, and only hands off once the
//   register is free.
// Reset restores the register defaults; the bin memory is not cleared, and
//   every bin must be written before a draw reads it.
module spectrum_bar_graph_renderer import sbgr_pkg::*; #(
  parameter int MAX_BINS      = MAX_BINS_DEF,
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: bin_index[9:0], magnitude_a[25:10], magnitude_b[41:26],
  //        column_index[51:42], zero pad [55:52]
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [55:0]          s_axis_tdata,
  input  logic                 s_axis_tuser,   // opcode
  // tdata: rect_left[11:0], rect_right[23:12], rect_top[33:24],
  //        rect_bottom[43:34], level[59:44], zero pad [63:60]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,
  output logic                 m_axis_tuser,   // fill
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

`include "spectrum_bar_graph_renderer_defines.svh"

  localparam int AW  = $clog2(MAX_BINS);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int CIW = $clog2(CURVE_ENTRIES);

  // ---------------------------------------------------------------------
  // log curve ROM, built at elaboration: Q0.16 of (e^(X t) - 1) over
  // (e^X - 1)
  // ---------------------------------------------------------------------
  typedef logic [16:0] curve_arr_t [CURVE_ENTRIES];

  // shift-and-subtract long division, elaboration only
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_q28(input longint unsigned x);
    longint unsigned term;
    longint unsigned sum;
    term = 64'd268435456;
    sum  = 64'd268435456;
    for (int k = 1; k <= 40; k++) begin
      term = udiv64((term * x) >> 28, longint'(k));
      sum  = sum + term;
    end
    return sum;
  endfunction

  function automatic curve_arr_t build_curve();
    curve_arr_t      rom;
    longint unsigned d;
    longint unsigned x;
    longint unsigned e;
    d = exp_q28(64'd679905027) - 64'd268435456;
    for (int i = 0; i < CURVE_ENTRIES; i++) begin
      x      = udiv64(64'd679905027 * longint'(i), longint'(CURVE_ENTRIES));
      e      = exp_q28(x) - 64'd268435456;
      rom[i] = 17'(udiv64(e * 64'd65536 + (d >> 1), d));
    end
    return rom;
  endfunction

  localparam curve_arr_t CURVE = build_curve();

  // ---------------------------------------------------------------------
  // sequencer states (one-hot) and mapping phases
  // ---------------------------------------------------------------------
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_MAP   = 10'b00_0000_0010,
    ST_DIV   = 10'b00_0000_0100,
    ST_ROM   = 10'b00_0000_1000,
    ST_MUL   = 10'b00_0001_0000,
    ST_WALK  = 10'b00_0010_0000,
    ST_DRAIN = 10'b00_0100_0000,
    ST_SCALE = 10'b00_1000_0000,
    ST_LVL   = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_END,
    PH_LEVEL,
    PH_TOP
  } phase_e;

  // configuration
  logic [10:0] bin_count_q;
  logic [1:0]  channel_count_q;
  logic        draw_mode_q;
  logic [10:0] area_width_q;
  logic [9:0]  area_height_q;
  logic        horizontal_log_q;
  logic        vertical_log_q;

  // sequencer
  state_e      state_q, state_d;
  phase_e      ph_q, ph_d;
  logic [9:0]  col_q, col_d;
  logic [CW-1:0] cols_q, cols_d;
  logic        oor_q, oor_d;
  logic [10:0] start_q, start_d;
  logic [10:0] end_q, end_d;
  logic [10:0] j_q, j_d;
  logic [28:0] sum_q;
  logic        rdv_q;
  logic [44:0] prod_q;
  logic [15:0] level_q, level_d;
  logic [9:0]  top_q, top_d;
  logic [CIW-1:0] rom_idx_q, rom_idx_d;
  logic        g_full_q, g_full_d;
  logic [16:0] rom_q;

  // output register
  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        out_fill_q;
  logic        out_free;
  logic        out_load;

  // bin memory
  logic [31:0] bin_mem [MAX_BINS];
  logic [31:0] mem_rd_q;
  logic        rd_en;
  logic        wr_en;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // request fields
  logic        in_acc;
  logic [9:0]  in_bin;
  logic [15:0] in_mag_a;
  logic [15:0] in_mag_b;
  logic [9:0]  in_col;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_bin   = s_axis_tdata[9:0];
  assign in_mag_a = s_axis_tdata[25:10];
  assign in_mag_b = s_axis_tdata[41:26];
  assign in_col   = s_axis_tdata[51:42];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign wr_en = in_acc && !s_axis_tuser && (32'(in_bin) < MAX_BINS);

  // ---------------------------------------------------------------------
  // column count: width saturated, /3 by reciprocal 2731/8192 in bar mode
  // ---------------------------------------------------------------------
  logic [CW-1:0]  width_sat;
  logic [CW+11:0] w3_prod;
  logic [CW-1:0]  cols_now;

  assign width_sat = (32'(area_width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(area_width_q);
  assign w3_prod   = width_sat * 12'd2731;
  assign cols_now  = draw_mode_q ? CW'(w3_prod >> 13) : width_sat;

  // ---------------------------------------------------------------------
  // shared mapping datapath
  // ---------------------------------------------------------------------
  logic [10:0] map_c;
  logic [15:0] map_num;
  logic [15:0] map_den;
  logic        map_log;
  logic [15:0] v_val;
  logic [16:0] g_val;
  logic [16:0] mul_b;
  logic [27:0] mul_p;
  logic [10:0] mul_round;
  logic [28:0] idx_prod;
  logic        nch2;
  logic [11:0] n_bins;
  logic [12:0] lvl_den;

  assign v_val = FULL_SCALE - level_q;
  assign nch2  = (channel_count_q == 2'd2);

  always_comb begin
    unique case (ph_q)
      PH_START: map_num = 16'(col_q);
      PH_END:   map_num = 16'(col_q) + 16'd1;
      default:  map_num = v_val;
    endcase
  end

  assign map_c   = (ph_q == PH_TOP) ? {1'b0, area_height_q} : bin_count_q;
  assign map_den = (ph_q == PH_TOP) ? FULL_SCALE : 16'(cols_q);
  assign map_log = (ph_q == PH_TOP) ? vertical_log_q : horizontal_log_q;

  assign g_val     = g_full_q ? 17'h10000 : rom_q;
  assign mul_b     = (state_q == ST_MUL) ? g_val : {1'b0, map_num};
  assign mul_p     = map_c * mul_b;
  assign mul_round = 11'((mul_p + 28'd32768) >> 16);
  assign idx_prod  = map_num * 13'(CURVE_ENTRIES);

  assign n_bins  = {1'b0, end_q} - {1'b0, start_q} + 12'd1;
  assign lvl_den = nch2 ? {n_bins, 1'b0} : {1'b0, n_bins};

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  logic        map_done;
  logic [10:0] map_val;
  logic [DIV_NUM_W-1:0] quot_hi;

  assign quot_hi = div_rsp.quot >> 16;

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    col_d     = col_q;
    cols_d    = cols_q;
    oor_d     = oor_q;
    start_d   = start_q;
    end_d     = end_q;
    j_d       = j_q;
    level_d   = level_q;
    top_d     = top_q;
    rom_idx_d = rom_idx_q;
    g_full_d  = g_full_q;
    div_req   = '0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    map_done  = 1'b0;
    map_val   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tuser) begin
          col_d  = in_col;
          cols_d = cols_now;
          ph_d   = PH_START;
          if (32'(in_col) >= 32'(cols_now)) begin
            oor_d   = 1'b1;
            state_d = ST_OUT;
          end else begin
            oor_d   = 1'b0;
            state_d = ST_MAP;
          end
        end
      end

      ST_MAP: begin
        if (ph_q == PH_TOP) begin
          if (!map_log) begin
            top_d   = 10'((mul_p + 28'd16384) >> 15);
            state_d = ST_OUT;
          end else if (v_val >= FULL_SCALE) begin
            g_full_d = 1'b1;
            state_d  = ST_MUL;
          end else begin
            g_full_d  = 1'b0;
            rom_idx_d = CIW'(idx_prod >> 15);
            state_d   = ST_ROM;
          end
        end else if (!map_log) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'({mul_p, 1'b0}) + DIV_NUM_W'(map_den);
          div_req.den   = DIV_DEN_W'({map_den, 1'b0});
          state_d       = ST_DIV;
        end else if (map_num >= map_den) begin
          g_full_d = 1'b1;
          state_d  = ST_MUL;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(idx_prod);
          div_req.den   = DIV_DEN_W'(map_den);
          state_d       = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          if (ph_q == PH_LEVEL) begin
            level_d = (quot_hi > DIV_NUM_W'(FULL_SCALE)) ? FULL_SCALE : 16'(quot_hi);
            ph_d    = PH_TOP;
            state_d = ST_MAP;
          end else if (!map_log) begin
            map_done = 1'b1;
            map_val  = 11'(div_rsp.quot);
          end else begin
            g_full_d  = 1'b0;
            rom_idx_d = (div_rsp.quot >= DIV_NUM_W'(CURVE_ENTRIES)) ?
                        CIW'(CURVE_ENTRIES - 1) : CIW'(div_rsp.quot);
            state_d   = ST_ROM;
          end
        end
      end

      ST_ROM: state_d = ST_MUL;

      ST_MUL: begin
        map_done = 1'b1;
        map_val  = mul_round;
      end

      ST_WALK: begin
        rd_en = (j_q < bin_count_q) && (32'(j_q) < MAX_BINS);
        if (j_q == end_q) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + 11'd1;
        end
      end

      ST_DRAIN: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_LVL;

      ST_LVL: begin
        div_req.start = 1'b1;
        div_req.num   = prod_q;
        div_req.den   = DIV_DEN_W'(lvl_den);
        ph_d          = PH_LEVEL;
        state_d       = ST_DIV;
      end

      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // a finished mapping lands according to the phase
    if (map_done) begin
      unique case (ph_q)
        PH_START: begin
          start_d = map_val;
          ph_d    = PH_END;
          state_d = ST_MAP;
        end
        PH_END: begin
          end_d   = (map_val < start_q) ? start_q : map_val;
          j_d     = start_q;
          state_d = ST_WALK;
        end
        default: begin
          top_d   = 10'(map_val);
          state_d = ST_OUT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ph_q    <= PH_START;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      rdv_q   <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q     <= col_d;
    cols_q    <= cols_d;
    oor_q     <= oor_d;
    start_q   <= start_d;
    end_q     <= end_d;
    j_q       <= j_d;
    level_q   <= level_d;
    top_q     <= top_d;
    rom_idx_q <= rom_idx_d;
    g_full_q  <= g_full_d;
    rom_q     <= CURVE[rom_idx_q];
    prod_q    <= sum_q * SCALE_080;
    // accumulate the bin read issued last cycle
    if (state_q == ST_MAP && ph_q == PH_END) begin
      sum_q <= '0;
    end else if (rdv_q) begin
      sum_q <= sum_q + 29'(mem_rd_q[15:0]) + (nch2 ? 29'(mem_rd_q[31:16]) : 29'd0);
    end
  end

  // ---------------------------------------------------------------------
  // bin memory: one write port (idle only), one read port for the walk
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bin_mem[AW'(in_bin)] <= {in_mag_b, in_mag_a};
    end
    if (rd_en) begin
      mem_rd_q <= bin_mem[AW'(j_q)];
    end
  end

  sbgr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------
  // result assembly and output register
  // ---------------------------------------------------------------------
  logic [11:0] res_left;
  logic [11:0] res_right;
  logic [9:0]  res_bottom;

  always_comb begin
    if (draw_mode_q) begin
      res_left   = 12'd1 + 12'd3 * 12'(col_q);
      res_right  = res_left + 12'd2;
      res_bottom = (area_height_q != '0) ? area_height_q - 10'd1 : 10'd0;
    end else begin
      res_left   = 12'(col_q);
      res_right  = 12'(col_q) + 12'd1;
      res_bottom = area_height_q;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (oor_q) begin
        out_data_q <= '0;
        out_fill_q <= 1'b0;
      end else begin
        out_data_q <= {4'd0, level_q, res_bottom, top_q, res_right, res_left};
        out_fill_q <= (res_bottom > top_q);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fill_q;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_count_q      <= 11'd512;
      channel_count_q  <= 2'd1;
      draw_mode_q      <= 1'b1;
      area_width_q     <= 11'd256;
      area_height_q    <= 10'd64;
      horizontal_log_q <= 1'b1;
      vertical_log_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIN_COUNT:      bin_count_q      <= cfg_wdata_i;
        CFG_CHANNEL_COUNT:  channel_count_q  <= cfg_wdata_i[1:0];
        CFG_DRAW_MODE:      draw_mode_q      <= cfg_wdata_i[0];
        CFG_AREA_WIDTH:     area_width_q     <= cfg_wdata_i;
        CFG_AREA_HEIGHT:    area_height_q    <= cfg_wdata_i[9:0];
        CFG_HORIZONTAL_LOG: horizontal_log_q <= cfg_wdata_i[0];
        CFG_VERTICAL_LOG:   vertical_log_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `SBGR_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy)
  `SBGR_ASSERT_IMP(a_rd_range, rd_en, (j_q < bin_count_q) && (32'(j_q) < MAX_BINS))
  `SBGR_ASSERT_IMP(a_walk_bound, state_q == ST_WALK, (j_q <= end_q) && (start_q <= end_q))
  `SBGR_ASSERT_NXT(a_out_load, (state_q == ST_OUT) && out_free,
                   out_valid_q && (state_q == ST_IDLE))

endmodule

// ===== tb/sv/spectrum_bar_graph_renderer_tb.sv =====
module spectrum_bar_graph_renderer_tb;
  import sbgr_pkg::*;

  localparam int NBINS = 1024;
  localparam int NWIDTH = 1024;
  localparam int NCURVE = 1024;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;  // no register here
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW = 1'b1;
  localparam longint unsigned Q28_ONE = 64'd268435456;
  localparam longint unsigned EXP_ARG = 64'd679905027;  // 1.1 ln 10, Q28
  localparam int CYCLE_LIMIT = 6000000;
  localparam int SETTLE_CYCLES = 1600;  // longer than the worst draw latency

  typedef struct packed {
    logic        op;
    logic [9:0]  bin;
    logic [15:0] mag_a;
    logic [15:0] mag_b;
    logic [9:0]  col;
  } request_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] right;
    logic [9:0]  top;
    logic [9:0]  bottom;
    logic        fill;
    logic [15:0] level;
  } rect_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  spectrum_bar_graph_renderer dut (.*);

  always #2 clk_i = ~clk_i;

  // shadow state of the block
  logic [31:0] bins_shadow [NBINS];
  longint unsigned curve_rom [NCURVE];
  logic [10:0] sh_bins = 11'd512;
  logic [1:0]  sh_chan = 2'd1;
  logic        sh_bar = 1'b1;
  logic [10:0] sh_width = 11'd256;
  logic [9:0]  sh_height = 10'd64;
  logic        sh_hlog = 1'b1;
  logic        sh_vlog = 1'b1;

  request_t pending_reqs[$];
  rect_t    rects_due[$];
  int       errors = 0;
  int       cyc = 0;
  request_t cur_req;

  function automatic longint unsigned exp_q28(longint unsigned x);
    longint unsigned term, acc;
    term = Q28_ONE;
    acc = Q28_ONE;
    for (int k = 1; k <= 40; k++) begin
      term = ((term * x) >> 28) / k;
      acc += term;
    end
    return acc;
  endfunction

  function automatic longint unsigned curve_at(longint unsigned num, longint unsigned den);
    longint unsigned idx;
    if (num >= den) return 64'd65536;
    idx = (num * NCURVE) / den;
    if (idx >= NCURVE) idx = NCURVE - 1;
    return curve_rom[idx];
  endfunction

  // round-half-up of count * f(num/den)
  function automatic longint unsigned map_val(longint unsigned count, longint unsigned num,
                                              longint unsigned den, logic use_log);
    if (use_log) return (count * curve_at(num, den) + 64'd32768) >> 16;
    return (2 * count * num + den) / (2 * den);
  endfunction

  function automatic rect_t draw_rect(logic [9:0] col);
    rect_t r;
    longint unsigned w, cols, lo, hi, acc, nch, lvl, top, left, right, bottom;
    r = '0;
    w = (sh_width > NWIDTH) ? NWIDTH : sh_width;
    cols = sh_bar ? w / 3 : w;
    if (col >= cols) return r;
    lo = map_val(sh_bins, col, cols, sh_hlog);
    hi = map_val(sh_bins, col + 1, cols, sh_hlog);
    if (hi < lo) hi = lo;
    nch = (sh_chan == 2'd2) ? 2 : 1;
    acc = 0;
    for (longint unsigned j = lo; j <= hi; j++)
      if (j < sh_bins && j < NBINS) begin
        acc += bins_shadow[j][15:0];
        if (nch == 2) acc += bins_shadow[j][31:16];
      end
    lvl = (acc * SCALE_080) / ((hi - lo + 1) * nch * 65536);
    if (lvl > FULL_SCALE) lvl = FULL_SCALE;
    top = map_val(sh_height, FULL_SCALE - lvl, FULL_SCALE, sh_vlog);
    if (sh_bar) begin
      left = 1 + 3 * col;
      right = left + 2;
      bottom = (sh_height != 0) ? sh_height - 1 : 0;
    end else begin
      left = col;
      right = col + 1;
      bottom = sh_height;
    end
    r.left = left[11:0];
    r.right = right[11:0];
    r.top = top[9:0];
    r.bottom = bottom[9:0];
    r.fill = (bottom > top);
    r.level = lvl[15:0];
    return r;
  endfunction

  initial begin
    longint unsigned d, x;
    d = exp_q28(EXP_ARG) - Q28_ONE;
    for (int i = 0; i < NCURVE; i++) begin
      x = (EXP_ARG * i) / NCURVE;
      curve_rom[i] = ((exp_q28(x) - Q28_ONE) * 65536 + d / 2) / d;
    end
  end

  // no idling at all inside this window
  function automatic bit idle_now();
    if (cyc > 30000 && cyc < 90000) return 1'b0;
    return ($urandom_range(0, 99) < 31);
  endfunction

  // driver: predicts each accepted request, then presents the next one
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        cur_req = pending_reqs.pop_front();
        if (cur_req.op == OP_WRITE) bins_shadow[cur_req.bin] = {cur_req.mag_b, cur_req.mag_a};
        else rects_due.push_back(draw_rect(cur_req.col));
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until taken
      end else if (pending_reqs.size() > 0 && !idle_now()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_reqs[0].op;
        s_axis_tdata <= {4'b0, pending_reqs[0].col, pending_reqs[0].mag_b,
                         pending_reqs[0].mag_a, pending_reqs[0].bin};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: compares each result against the oldest predicted rectangle
  always @(posedge clk_i) begin
    rect_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.left = m_axis_tdata[11:0];
        got.right = m_axis_tdata[23:12];
        got.top = m_axis_tdata[33:24];
        got.bottom = m_axis_tdata[43:34];
        got.level = m_axis_tdata[59:44];
        got.fill = m_axis_tuser;
        if (rects_due.size() == 0) begin
          $display("%0t unexpected result: exp none act %h", $time, got);
          errors++;
        end else begin
          want = rects_due.pop_front();
          if (got.left !== want.left)
            $display("%0t left: exp %0d act %0d", $time, want.left, got.left);
          if (got.right !== want.right)
            $display("%0t right: exp %0d act %0d", $time, want.right, got.right);
          if (got.top !== want.top)
            $display("%0t top: exp %0d act %0d", $time, want.top, got.top);
          if (got.bottom !== want.bottom)
            $display("%0t bottom: exp %0d act %0d", $time, want.bottom, got.bottom);
          if (got.fill !== want.fill)
            $display("%0t fill: exp %0d act %0d", $time, want.fill, got.fill);
          if (got.level !== want.level)
            $display("%0t level: exp %0d act %0d", $time, want.level, got.level);
          if (got !== want) errors++;
        end
      end
      m_axis_tready <= !idle_now();
    end
  end

  task automatic push_write(logic [9:0] bin, logic [15:0] a, logic [15:0] b);
    request_t r;
    r = '0;
    r.op = OP_WRITE;
    r.bin = bin;
    r.mag_a = a;
    r.mag_b = b;
    r.col = 10'($urandom());
    pending_reqs.push_back(r);
  endtask

  task automatic push_draw(logic [9:0] col);
    request_t r;
    r = '0;
    r.op = OP_DRAW;
    r.col = col;
    r.bin = 10'($urandom());
    r.mag_a = 16'($urandom());
    r.mag_b = 16'($urandom());
    pending_reqs.push_back(r);
  endtask

  // sender holds off until every request went in and every result came out
  task automatic drain();
    while (pending_reqs.size() > 0 || rects_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_BIN_COUNT: sh_bins = val[10:0];
      CFG_CHANNEL_COUNT: sh_chan = val[1:0];
      CFG_DRAW_MODE: sh_bar = val[0];
      CFG_AREA_WIDTH: sh_width = val[10:0];
      CFG_AREA_HEIGHT: sh_height = val[9:0];
      CFG_HORIZONTAL_LOG: sh_hlog = val[0];
      CFG_VERTICAL_LOG: sh_vlog = val[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(int nb, int ch, int md, int w, int h, int hl, int vl);
    cfg_write(CFG_BIN_COUNT, CFG_W'(nb));
    cfg_write(CFG_CHANNEL_COUNT, CFG_W'(ch));
    cfg_write(CFG_DRAW_MODE, CFG_W'(md));
    cfg_write(CFG_AREA_WIDTH, CFG_W'(w));
    cfg_write(CFG_AREA_HEIGHT, CFG_W'(h));
    cfg_write(CFG_HORIZONTAL_LOG, CFG_W'(hl));
    cfg_write(CFG_VERTICAL_LOG, CFG_W'(vl));
  endtask

  function automatic int col_count();
    int w;
    w = (sh_width > NWIDTH) ? NWIDTH : sh_width;
    return sh_bar ? w / 3 : w;
  endfunction

  initial begin
    int cols;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // fill the whole bin memory first so no draw reads an unwritten bin
    for (int i = 0; i < NBINS; i++) push_write(10'(i), 16'($urandom()), 16'($urandom()));
    drain();

    // directed: reset defaults, extreme magnitudes, out-of-range columns
    push_write(0, 16'hFFFF, 16'hFFFF);
    push_write(1, 16'h0000, 16'h0000);
    push_write(2, 16'h8000, 16'h7FFF);
    push_draw(0);
    push_draw(1);
    push_draw(84);
    push_draw(85);       // first column past the count
    push_draw(10'h3FF);
    drain();
    // unknown register index must leave everything alone
    cfg_write(CFG_UNUSED_IDX, 11'h7FF);
    set_all(1024, 2, 0, 1024, 1023, 0, 0);
    push_draw(0);
    push_draw(1023);
    push_draw(512);
    drain();
    // zero bin count, wide area saturating, odd channel count
    set_all(0, 3, 0, 2047, 1023, 1, 1);
    push_draw(0);
    push_draw(1023);
    drain();
    // no columns at all in bar mode, zero height, channel count zero
    set_all(1, 0, 1, 2, 0, 1, 0);
    push_draw(0);
    push_draw(1);
    drain();
    set_all(16, 2, 1, 1024, 1, 0, 1);
    push_draw(0);
    push_draw(340);
    push_draw(341);
    drain();

    // random phases
    for (int p = 0; p < 10; p++) begin
      set_all(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1024) : $urandom_range(1, 64),
              $urandom_range(0, 3), $urandom_range(0, 1),
              ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047) : $urandom_range(300, 1024),
              $urandom_range(0, 1023), $urandom_range(0, 1), $urandom_range(0, 1));
      cols = col_count();
      for (int k = 0; k < 80; k++) begin
        if ($urandom_range(0, 2) == 0)
          push_write(10'($urandom()), 16'($urandom()), 16'($urandom()));
        else if (cols > 0 && $urandom_range(0, 9) != 0)
          push_draw(10'($urandom_range(0, cols - 1)));
        else push_draw(10'($urandom()));
      end
      drain();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== spectrum_bar_graph_renderer.f =====
+incdir+rtl
rtl/sbgr_pkg.sv
rtl/sbgr_div.sv
rtl/spectrum_bar_graph_renderer.sv
tb/sv/spectrum_bar_graph_renderer_tb.sv
